### hdl/tdp_pkg.sv
// Shared types, constants and helpers for the time-of-day text parser.
package tdp_pkg;

  localparam int CHAR_W          = 8;
  localparam int ACC_W           = 10;
  localparam int HRS_W           = 5;
  localparam int MIN_W           = 6;
  localparam int FRAC_W          = 10;
  localparam int FCNT_W          = 2;
  localparam int SEC_TOTAL_W     = 17;
  localparam int MS_W            = 27;
  localparam int FRACTION_DIGITS = 3;

  localparam logic [ACC_W-1:0]  ACC_MAX      = 10'd1023;
  localparam logic [ACC_W-1:0]  HRS_LIMIT    = 10'd24;
  localparam logic [ACC_W-1:0]  MIN_LIMIT    = 10'd60;
  localparam logic [ACC_W-1:0]  FRAC_LIMIT   = 10'd1000;
  localparam logic [FCNT_W-1:0] FRAC_DIG_MAX = FCNT_W'(FRACTION_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_HOURS,
    PH_MINUTES,
    PH_SECONDS,
    PH_FRACTION
  } phase_e;

  typedef struct packed {
    logic              ok;
    logic [HRS_W-1:0]  hrs;
    logic [MIN_W-1:0]  mins;
    logic [MIN_W-1:0]  secs;
    logic [FRAC_W-1:0] frac;
  } tdp_rec_t;

  function automatic logic field_ok(input logic [ACC_W-1:0] acc, input logic minus,
                                    input logic has_digit, input logic [ACC_W-1:0] limit);
    field_ok = has_digit && !(minus && (acc != '0)) && (acc < limit);
  endfunction

endpackage

### hdl/tdp_in_if.sv
// Character input channel: at most one string byte per beat.
interface tdp_in_if import tdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_present;
  logic              is_last;

  modport source (output valid, output char_code, output char_present, output is_last,
                  input ready);
  modport sink   (input valid, input char_code, input char_present, input is_last,
                  output ready);
endinterface

### hdl/tdp_out_if.sv
// Result channel: validity flag and milliseconds since midnight.
interface tdp_out_if import tdp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            time_valid;
  logic [MS_W-1:0] time_ms;

  modport source (output valid, output time_valid, output time_ms, input ready);
  modport sink   (input valid, input time_valid, input time_ms, output ready);
endinterface

### hdl/tdp_char_parse.sv
// Per-character field parser with a registered end-of-string record.
module tdp_char_parse import tdp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic     char_present_i,
  input  logic     is_last_i,
  output logic     rec_valid_o,
  input  logic     rec_ready_i,
  output tdp_rec_t rec_o
);

  phase_e            ph_q, ph_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              minus_q, minus_d;
  logic              hasd_q, hasd_d;
  logic [FCNT_W-1:0] fch_q, fch_d;
  logic [HRS_W-1:0]  hrs_q, hrs_d;
  logic [MIN_W-1:0]  min_q, min_d;
  logic [MIN_W-1:0]  sec_q, sec_d;
  logic              fail_q, fail_d;
  logic              rec_valid_q, rec_valid_d;
  tdp_rec_t          rec_q, rec_d;

  logic              accept;
  logic              is_digit;
  logic [13:0]       acc_prod;
  logic [ACC_W-1:0]  ab_acc;
  logic              ab_minus;
  logic              ab_hasd;
  logic              ab_fail;
  logic [16:0]       frac_wide;

  assign ready_o = !rec_valid_q || rec_ready_i;
  assign accept  = valid_i && ready_o;

  // digit, minus-sign and reject handling for the current field
  always_comb begin
    is_digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
    acc_prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, char_code_i[3:0]};
    ab_acc   = acc_q;
    ab_minus = minus_q;
    ab_hasd  = hasd_q;
    ab_fail  = fail_q;
    if (is_digit) begin
      ab_acc  = (acc_prod > {4'd0, ACC_MAX}) ? ACC_MAX : acc_prod[ACC_W-1:0];
      ab_hasd = 1'b1;
    end else if ((char_code_i == CHAR_MINUS) && !minus_q && !hasd_q) begin
      ab_minus = 1'b1;
    end else begin
      ab_fail = 1'b1;
    end
  end

  always_comb begin
    ph_d    = ph_q;
    acc_d   = acc_q;
    minus_d = minus_q;
    hasd_d  = hasd_q;
    fch_d   = fch_q;
    hrs_d   = hrs_q;
    min_d   = min_q;
    sec_d   = sec_q;
    fail_d  = fail_q;
    rec_d   = rec_q;
    frac_wide = '0;
    rec_valid_d = rec_ready_i ? 1'b0 : rec_valid_q;

    if (accept && char_present_i && !fail_q) begin
      if (ph_q == PH_FRACTION) begin
        if (fch_q < FRAC_DIG_MAX) begin
          fch_d   = fch_q + 1'b1;
          acc_d   = ab_acc;
          minus_d = ab_minus;
          hasd_d  = ab_hasd;
          fail_d  = ab_fail;
        end
      end else if ((char_code_i == CHAR_COLON) && (ph_q == PH_HOURS)) begin
        if (field_ok(acc_q, minus_q, hasd_q, HRS_LIMIT)) begin
          hrs_d = acc_q[HRS_W-1:0];
          ph_d  = PH_MINUTES;
          acc_d = '0; minus_d = 1'b0; hasd_d = 1'b0;
        end else begin
          fail_d = 1'b1;
        end
      end else if ((char_code_i == CHAR_COLON) && (ph_q == PH_MINUTES)) begin
        if (field_ok(acc_q, minus_q, hasd_q, MIN_LIMIT)) begin
          min_d = acc_q[MIN_W-1:0];
          ph_d  = PH_SECONDS;
          acc_d = '0; minus_d = 1'b0; hasd_d = 1'b0;
        end else begin
          fail_d = 1'b1;
        end
      end else if ((char_code_i == CHAR_DOT) && (ph_q == PH_SECONDS)) begin
        if (field_ok(acc_q, minus_q, hasd_q, MIN_LIMIT)) begin
          sec_d = acc_q[MIN_W-1:0];
          ph_d  = PH_FRACTION;
          fch_d = '0;
          acc_d = '0; minus_d = 1'b0; hasd_d = 1'b0;
        end else begin
          fail_d = 1'b1;
        end
      end else begin
        acc_d   = ab_acc;
        minus_d = ab_minus;
        hasd_d  = ab_hasd;
        fail_d  = ab_fail;
      end
    end

    if (accept && is_last_i) begin
      rec_d = '0;
      case (fch_d)
        2'd1:    frac_wide = 17'(acc_d) * 17'd100;
        2'd2:    frac_wide = 17'(acc_d) * 17'd10;
        default: frac_wide = 17'(acc_d);
      endcase
      if (!fail_d) begin
        case (ph_d)
          PH_SECONDS: begin
            if (field_ok(acc_d, minus_d, hasd_d, MIN_LIMIT)) begin
              rec_d.ok   = 1'b1;
              rec_d.hrs  = hrs_d;
              rec_d.mins = min_d;
              rec_d.secs = acc_d[MIN_W-1:0];
            end
          end
          PH_FRACTION: begin
            if ((fch_d != '0) && field_ok(acc_d, minus_d, hasd_d, FRAC_LIMIT)) begin
              rec_d.ok   = 1'b1;
              rec_d.hrs  = hrs_d;
              rec_d.mins = min_d;
              rec_d.secs = sec_d;
              rec_d.frac = frac_wide[FRAC_W-1:0];
            end
          end
          default: rec_d.ok = 1'b0;
        endcase
      end
      rec_valid_d = 1'b1;
      // return to the start of a new string
      ph_d    = PH_HOURS;
      acc_d   = '0;
      minus_d = 1'b0;
      hasd_d  = 1'b0;
      fch_d   = '0;
      hrs_d   = '0;
      min_d   = '0;
      sec_d   = '0;
      fail_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_HOURS;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      hasd_q      <= 1'b0;
      fch_q       <= '0;
      hrs_q       <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      fail_q      <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      ph_q        <= ph_d;
      acc_q       <= acc_d;
      minus_q     <= minus_d;
      hasd_q      <= hasd_d;
      fch_q       <= fch_d;
      hrs_q       <= hrs_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      fail_q      <= fail_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

### hdl/tdp_ms_calc.sv
// Two-stage conversion of a parsed time record to milliseconds, with output register.
module tdp_ms_calc import tdp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_valid_i,
  output logic            rec_ready_o,
  input  tdp_rec_t        rec_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            time_valid_o,
  output logic [MS_W-1:0] time_ms_o
);

  logic                   s1_valid_q;
  logic                   s1_ok_q;
  logic [SEC_TOTAL_W-1:0] s1_sec_q, s1_sec_d;
  logic [FRAC_W-1:0]      s1_frac_q;
  logic                   out_valid_q;
  logic                   out_ok_q;
  logic [MS_W-1:0]        out_ms_q, out_ms_d;
  logic                   out_take;
  logic                   s1_take;

  assign out_take    = !out_valid_q || ready_i;
  assign s1_take     = !s1_valid_q || out_take;
  assign rec_ready_o = s1_take;

  assign s1_sec_d = SEC_TOTAL_W'(rec_i.hrs) * SEC_TOTAL_W'(3600)
                  + SEC_TOTAL_W'(rec_i.mins) * SEC_TOTAL_W'(60)
                  + SEC_TOTAL_W'(rec_i.secs);
  assign out_ms_d = MS_W'(s1_sec_q) * MS_W'(1000) + MS_W'(s1_frac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= rec_valid_i;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && rec_valid_i) begin
      s1_ok_q   <= rec_i.ok;
      s1_sec_q  <= s1_sec_d;
      s1_frac_q <= rec_i.frac;
    end
    if (out_take && s1_valid_q) begin
      out_ok_q <= s1_ok_q;
      out_ms_q <= out_ms_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign time_valid_o = out_ok_q;
  assign time_ms_o    = out_ms_q;

endmodule

### hdl/time_of_day_text_parser_top.sv
// Top level of the time-of-day text parser.
// Takes an "hh:mm:ss[.fff]" string one character per beat, any number of beats
// back to back, and gives one result beat per string, on the beat marked last:
// a valid flag and the time in milliseconds since midnight (zero when invalid).
// After the last beat is accepted, the result passes three registers: the character
// parser's record, the seconds total, and the millisecond product in the output
// register. Input stalls only when all three stages hold results waiting for the
// output side.
module time_of_day_text_parser_top import tdp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  tdp_in_if.sink    in_i,
  tdp_out_if.source out_o
);

  logic     rec_valid;
  logic     rec_ready;
  tdp_rec_t rec;

  tdp_char_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_i.valid),
    .ready_o        (in_i.ready),
    .char_code_i    (in_i.char_code),
    .char_present_i (in_i.char_present),
    .is_last_i      (in_i.is_last),
    .rec_valid_o    (rec_valid),
    .rec_ready_i    (rec_ready),
    .rec_o          (rec)
  );

  tdp_ms_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (rec_valid),
    .rec_ready_o  (rec_ready),
    .rec_i        (rec),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .time_valid_o (out_o.time_valid),
    .time_ms_o    (out_o.time_ms)
  );

endmodule

### test/time_of_day_text_parser_top_test.sv
// Self-checking testbench for time_of_day_text_parser_top: per-character time string parsing.
module time_of_day_text_parser_top_test import tdp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef logic [CHAR_W-1:0] text_t[$];

  typedef struct {
    logic            valid_flag;
    logic [MS_W-1:0] ms;
  } clock_time_t;

  logic clk_i;
  logic rst_ni;

  tdp_in_if  in_if();
  tdp_out_if out_if();

  time_of_day_text_parser_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  clock_time_t expected_times[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_wanted = 1'b0;

  phase_e              ph;
  logic [ACC_W-1:0]    acc;
  logic                neg;
  logic                seen_digit;
  logic [FCNT_W-1:0]   frac_taken;
  logic [HRS_W-1:0]    hrs_q;
  logic [MIN_W-1:0]    min_q;
  logic [MIN_W-1:0]    sec_q;
  logic                rejected;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic clear_field();
    acc        = '0;
    neg        = 1'b0;
    seen_digit = 1'b0;
  endtask

  task automatic clear_parse();
    clear_field();
    ph         = PH_HOURS;
    frac_taken = '0;
    hrs_q      = '0;
    min_q      = '0;
    sec_q      = '0;
    rejected   = 1'b0;
  endtask

  function automatic logic field_passes(input int unsigned limit);
    if (!seen_digit) return 1'b0;
    if (neg && acc != '0) return 1'b0;
    return int'(acc) < limit;
  endfunction

  task automatic absorb_char(input logic [CHAR_W-1:0] c);
    int unsigned nxt;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      nxt = int'(acc) * 10 + int'(c - CHAR_ZERO);
      acc = (nxt > int'(ACC_MAX)) ? ACC_MAX : nxt[ACC_W-1:0];
      seen_digit = 1'b1;
    end else if (c == CHAR_MINUS && !neg && !seen_digit) begin
      neg = 1'b1;
    end else begin
      rejected = 1'b1;
    end
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c);
    if (rejected) return;
    if (ph == PH_FRACTION) begin
      if (frac_taken >= FRAC_DIG_MAX) return;
      frac_taken++;
      absorb_char(c);
    end else if (c == CHAR_COLON && ph == PH_HOURS) begin
      if (!field_passes(HRS_LIMIT)) begin
        rejected = 1'b1;
      end else begin
        hrs_q = acc[HRS_W-1:0];
        ph    = PH_MINUTES;
        clear_field();
      end
    end else if (c == CHAR_COLON && ph == PH_MINUTES) begin
      if (!field_passes(MIN_LIMIT)) begin
        rejected = 1'b1;
      end else begin
        min_q = acc[MIN_W-1:0];
        ph    = PH_SECONDS;
        clear_field();
      end
    end else if (c == CHAR_DOT && ph == PH_SECONDS) begin
      if (!field_passes(MIN_LIMIT)) begin
        rejected = 1'b1;
      end else begin
        sec_q      = acc[MIN_W-1:0];
        ph         = PH_FRACTION;
        frac_taken = '0;
        clear_field();
      end
    end else begin
      absorb_char(c);
    end
  endtask

  task automatic close_string();
    clock_time_t rec;
    int unsigned frac;
    int unsigned total;
    rec.valid_flag = 1'b0;
    rec.ms         = '0;
    frac           = 0;
    if (!rejected) begin
      if (ph == PH_SECONDS && field_passes(MIN_LIMIT)) begin
        sec_q          = acc[MIN_W-1:0];
        rec.valid_flag = 1'b1;
      end else if (ph == PH_FRACTION && frac_taken != '0 && field_passes(FRAC_LIMIT)) begin
        frac = acc;
        for (int k = frac_taken; k < 3; k++) frac = frac * 10;
        rec.valid_flag = 1'b1;
      end
    end
    if (rec.valid_flag) begin
      total  = hrs_q;
      total  = (total * 60 + min_q) * 60 + sec_q;
      total  = total * 1000 + frac;
      rec.ms = total[MS_W-1:0];
    end
    expected_times.push_back(rec);
    clear_parse();
  endtask

  task automatic send_beat(input logic [CHAR_W-1:0] code, input logic present,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.char_code    <= code;
    in_if.char_present <= present;
    in_if.is_last      <= last;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    if (present) parse_char(code);
    if (last) close_string();
  endtask

  task automatic send_text(input text_t t);
    bit trail_empty;
    trail_empty = (t.size() == 0) || ($urandom_range(9) == 0);
    foreach (t[i]) begin
      if ($urandom_range(19) == 0) send_beat(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(t[i], 1'b1, !trail_empty && (i == t.size() - 1));
    end
    if (trail_empty) send_beat(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
    chars_sent += t.size();
  endtask

  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_times.size() != 0) @(posedge clk_i);
  endtask

  function automatic text_t to_text(input string s);
    text_t t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  function automatic int unsigned pick_value(input int unsigned limit);
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return $urandom_range(limit + 20, limit);
    if (r == 1) return $urandom_range(99999, 1000);
    return $urandom_range(limit - 1);
  endfunction

  task automatic append_field(ref text_t t, input int unsigned v);
    string       s;
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return;
    if (r == 1 || (v == 0 && r < 4)) t.push_back(CHAR_MINUS);
    if (r == 5) repeat ($urandom_range(3, 1)) t.push_back(CHAR_ZERO);
    s = $sformatf("%0d", v);
    foreach (s[i]) t.push_back(s[i]);
  endtask

  task automatic make_time(ref text_t t);
    int unsigned nf;
    int unsigned idx;
    logic [CHAR_W-1:0] odd_chars[6];
    odd_chars = '{CHAR_COLON, CHAR_DOT, CHAR_MINUS, 8'h2B, 8'h20, CHAR_NINE};
    append_field(t, pick_value(HRS_LIMIT));
    t.push_back(CHAR_COLON);
    append_field(t, pick_value(MIN_LIMIT));
    t.push_back(CHAR_COLON);
    append_field(t, pick_value(MIN_LIMIT));
    if ($urandom_range(3) != 0) begin
      t.push_back(CHAR_DOT);
      nf = $urandom_range(5);
      for (int k = 0; k < nf; k++) begin
        if (k == 0 && $urandom_range(15) == 0) t.push_back(CHAR_MINUS);
        else t.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
      end
    end
    if ($urandom_range(7) == 0) begin
      idx = $urandom_range(t.size() - 1);
      case ($urandom_range(2))
        0: t[idx] = CHAR_W'($urandom_range(255));
        1: t.insert(idx, odd_chars[$urandom_range(5)]);
        default: t.delete(idx);
      endcase
    end
  endtask

  task automatic make_noise(ref text_t t);
    repeat ($urandom_range(8, 1)) begin
      if ($urandom_range(1) == 0) t.push_back(CHAR_W'($urandom_range(255)));
      else t.push_back(CHAR_W'($urandom_range(CHAR_COLON, CHAR_MINUS)));
    end
  endtask

  task automatic test_directed_cases();
    string cases[$];
    text_t odd_byte;
    cases = '{"0:0:0", "23:59:59.999", "24:0:0", "0:60:0", "0:0:60", "-0:-00:-0",
              "-1:0:0", "1:2:3.4", "1:2:3.45", "1:2:3.", "1:2:3.5678+", "1:2", "",
              "1:2:3:4", "1.2:3", "+1:0:0", "99999:0:0", "007:08:09", "--0:0:0",
              "0-:0:0", "1:2:3.-0", "1:2:3.-5", "1:2::3", ":", "1:2:3 "};
    send_idle_pct = 15;
    recv_idle_pct = 73;
    foreach (cases[i]) send_text(to_text(cases[i]));
    odd_byte = '{8'hFF, CHAR_COLON, 8'h00};
    send_text(odd_byte);
    wait_results_done();
  endtask

  task automatic test_input_stall();
    text_t t;
    send_idle_pct = 0;
    hold_wanted <= 1'b1;
    repeat (12) begin
      t.delete();
      make_time(t);
      send_text(t);
    end
    wait_results_done();
  endtask

  task automatic test_random_times(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned target);
    int unsigned start;
    text_t       t;
    start         = chars_sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (chars_sent - start < target) begin
      t.delete();
      if ($urandom_range(9) == 0) make_noise(t);
      else make_time(t);
      send_text(t);
      if ($urandom_range(39) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_wanted) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_wanted <= 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    clock_time_t want;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_times.size() == 0) begin
        $error("unexpected result beat: time_valid %0d time_ms %0d",
               out_if.time_valid, out_if.time_ms);
        error_count++;
      end else begin
        want = expected_times.pop_front();
        if (out_if.time_valid !== want.valid_flag) begin
          $error("time_valid: expected %0d, got %0d", want.valid_flag, out_if.time_valid);
          error_count++;
        end
        if (out_if.time_ms !== want.ms) begin
          $error("time_ms: expected %0d, got %0d", want.ms, out_if.time_ms);
          error_count++;
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("time_of_day_text_parser_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.char_code    <= '0;
    in_if.char_present <= 1'b0;
    in_if.is_last      <= 1'b0;
    clear_parse();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_input_stall();
    test_random_times(15, 73, 240);
    test_random_times(73, 15, 240);
    test_random_times(0, 0, 240);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_times.size() == 0)
      $display("time_of_day_text_parser_top verification clean");
    else
      $display("time_of_day_text_parser_top verification failed");
    $finish;
  end

endmodule
